// ----- hw/rtl/rte_pkg.sv -----
// Shared package for the rigid transform block: widths, register indexes,
// CORDIC constants, the arctangent table and the interface types.
// No dependencies.
`default_nettype none
package rte_pkg;

	localparam int CORDIC_STEPS    = 16;
	localparam int COORD_FRAC_BITS = 16;
	localparam int ATAN_LEN        = 24;
	localparam int CORDIC_ITERS    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int STEP_W          = $clog2(ATAN_LEN);

	localparam int ANG_W   = 16;
	localparam int COORD_W = 32;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;
	localparam int CZ_W    = 34;   // CORDIC x, y, z working width
	localparam int TRIG_W  = 32;   // stored sine and cosine
	localparam int COEF_W  = 33;   // matrix coefficients
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = COEF_W + DIFF_W;
	localparam int RND_W   = PROD_W - 30;
	localparam int ACC_W   = RND_W + 2;

	localparam logic signed [CZ_W-1:0] GAIN_Q30     = CZ_W'(652032874);
	localparam logic signed [CZ_W-1:0] QUARTER_TURN = CZ_W'(64'sd1 <<< 30);
	localparam logic signed [CZ_W-1:0] HALF_TURN    = CZ_W'(64'sd1 <<< 31);

	localparam logic [IDX_W-1:0] REG_ROLL    = 3'd0;
	localparam logic [IDX_W-1:0] REG_PITCH   = 3'd1;
	localparam logic [IDX_W-1:0] REG_YAW     = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFFSET_X = 3'd3;
	localparam logic [IDX_W-1:0] REG_OFFSET_Y = 3'd4;
	localparam logic [IDX_W-1:0] REG_OFFSET_Z = 3'd5;
	localparam logic [IDX_W-1:0] REG_INVERSE = 3'd6;

	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ANG_W-1:0]   angle_t;
	typedef coef_t mat_t [3][3];

	typedef struct {
		mat_t   mat;
		coord_t offset [3];
		logic   inverse;
	} xform_t;

	// arctangent of 2^-i, pi = 2^31
	function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rte_matrix.sv -----
// Rotation matrix builder: shared iterative CORDIC for the three angles,
// then one shared multiplier forms the Z-Y-X matrix entries. Uses rte_pkg.
`default_nettype none
module rte_matrix (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  rte_pkg::angle_t       roll,
	input  rte_pkg::angle_t       pitch,
	input  rte_pkg::angle_t       yaw,
	output rte_pkg::mat_t         mat,
	output logic                  ready
);

	typedef enum logic [4:0] {
		ST_LOAD = 5'b00001,
		ST_ITER = 5'b00010,
		ST_MULT = 5'b00100,
		ST_SUM  = 5'b01000,
		ST_DONE = 5'b10000
	} mst_t;

	localparam int NPROD = 14;
	localparam logic [3:0] LAST_MSTEP = 4'(NPROD - 1);
	localparam logic [rte_pkg::STEP_W-1:0] LAST_STEP =
		rte_pkg::STEP_W'(rte_pkg::CORDIC_ITERS - 1);
	localparam logic signed [65:0] RND_HALF = 66'sd1 <<< 29;

	// trig index: 0 roll, 1 pitch, 2 yaw
	localparam logic [1:0] A_ROLL = 2'd0;
	localparam logic [1:0] A_PITCH = 2'd1;
	localparam logic [1:0] A_YAW = 2'd2;

	mst_t state_q;
	logic [1:0] ang_q;
	logic [rte_pkg::STEP_W-1:0] step_q;
	logic [3:0] mstep_q;
	logic signed [rte_pkg::CZ_W-1:0] x_q, y_q, z_q;
	logic neg_q;
	logic signed [rte_pkg::TRIG_W-1:0] sin_q [3];
	logic signed [rte_pkg::TRIG_W-1:0] cos_q [3];
	rte_pkg::coef_t prod_q [NPROD];
	rte_pkg::mat_t mat_q;

	logic signed [rte_pkg::CZ_W-1:0] z_in, z_fold, xs, ys, atn, nx, ny, nz, fx, fy;
	logic fold;
	rte_pkg::angle_t ang_sel;
	rte_pkg::coef_t op_a, op_b, sr, cr, sp, cp, sy, cy;
	logic signed [65:0] mprod, mrnd;

	always_comb begin
		case (ang_q)
			A_ROLL:  ang_sel = roll;
			A_PITCH: ang_sel = pitch;
			default: ang_sel = yaw;
		endcase
		z_in = {{(rte_pkg::CZ_W-32){ang_sel[15]}}, ang_sel, 16'd0};
		fold = 1'b0;
		z_fold = z_in;
		if (z_in > rte_pkg::QUARTER_TURN) begin
			z_fold = z_in - rte_pkg::HALF_TURN;
			fold = 1'b1;
		end else if (z_in < -rte_pkg::QUARTER_TURN) begin
			z_fold = z_in + rte_pkg::HALF_TURN;
			fold = 1'b1;
		end
	end

	// one CORDIC micro-rotation
	always_comb begin
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		atn = rte_pkg::CZ_W'(rte_pkg::atan_lut(step_q));
		if (!z_q[rte_pkg::CZ_W-1]) begin
			nx = x_q - ys;
			ny = y_q + xs;
			nz = z_q - atn;
		end else begin
			nx = x_q + ys;
			ny = y_q - xs;
			nz = z_q + atn;
		end
		fx = neg_q ? -nx : nx;
		fy = neg_q ? -ny : ny;
	end

	always_comb begin
		sr = rte_pkg::COEF_W'(sin_q[A_ROLL]);
		cr = rte_pkg::COEF_W'(cos_q[A_ROLL]);
		sp = rte_pkg::COEF_W'(sin_q[A_PITCH]);
		cp = rte_pkg::COEF_W'(cos_q[A_PITCH]);
		sy = rte_pkg::COEF_W'(sin_q[A_YAW]);
		cy = rte_pkg::COEF_W'(cos_q[A_YAW]);
		case (mstep_q)
			4'd0:  begin op_a = cy;         op_b = cp; end
			4'd1:  begin op_a = cy;         op_b = sp; end
			4'd2:  begin op_a = prod_q[1];  op_b = sr; end
			4'd3:  begin op_a = sy;         op_b = cr; end
			4'd4:  begin op_a = prod_q[1];  op_b = cr; end
			4'd5:  begin op_a = sy;         op_b = sr; end
			4'd6:  begin op_a = sy;         op_b = cp; end
			4'd7:  begin op_a = sy;         op_b = sp; end
			4'd8:  begin op_a = prod_q[7];  op_b = sr; end
			4'd9:  begin op_a = cy;         op_b = cr; end
			4'd10: begin op_a = prod_q[7];  op_b = cr; end
			4'd11: begin op_a = cy;         op_b = sr; end
			4'd12: begin op_a = cp;         op_b = sr; end
			4'd13: begin op_a = cp;         op_b = cr; end
			default: begin op_a = '0;       op_b = '0; end
		endcase
		mprod = 66'(op_a) * 66'(op_b);
		mrnd  = (mprod + RND_HALF) >>> 30;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ang_q   <= A_ROLL;
			step_q  <= '0;
			mstep_q <= '0;
		end else if (start) begin
			state_q <= ST_LOAD;
			ang_q   <= A_ROLL;
		end else begin
			case (state_q)
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						if (ang_q == A_YAW) begin
							mstep_q <= '0;
							state_q <= ST_MULT;
						end else begin
							ang_q   <= ang_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_MULT: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == LAST_MSTEP)
						state_q <= ST_SUM;
				end
				ST_SUM:  state_q <= ST_DONE;
				ST_DONE: state_q <= ST_DONE;
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			x_q   <= rte_pkg::GAIN_Q30;
			y_q   <= '0;
			z_q   <= z_fold;
			neg_q <= fold;
		end else if (state_q == ST_ITER) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
			if (step_q == LAST_STEP) begin
				cos_q[ang_q] <= rte_pkg::TRIG_W'(fx);
				sin_q[ang_q] <= rte_pkg::TRIG_W'(fy);
			end
		end
		if (state_q == ST_MULT)
			prod_q[mstep_q] <= rte_pkg::COEF_W'(mrnd);
		mat_q[0][0] <= prod_q[0];
		mat_q[0][1] <= prod_q[2] - prod_q[3];
		mat_q[0][2] <= prod_q[4] + prod_q[5];
		mat_q[1][0] <= prod_q[6];
		mat_q[1][1] <= prod_q[8] + prod_q[9];
		mat_q[1][2] <= prod_q[10] - prod_q[11];
		mat_q[2][0] <= -sp;
		mat_q[2][1] <= prod_q[12];
		mat_q[2][2] <= prod_q[13];
	end

	assign mat   = mat_q;
	assign ready = (state_q == ST_DONE);

	a_restart_clears_ready: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !ready) else $error("matrix ready right after restart");
	a_done_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready) |-> $past(state_q) == ST_SUM) else $error("ready without sum cycle");

endmodule
`default_nettype wire

// ----- hw/rtl/rte_pipe.sv -----
// Four-stage point datapath: inverse offset subtract, nine products, rounding
// sum + forward offset, clamp. Each stage advances into bubbles. Uses rte_pkg.
`default_nettype none
module rte_pipe (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  rte_pkg::xform_t      xf,
	input  wire logic            take,
	output logic                 room,
	input  rte_pkg::coord_t      pin [3],
	output logic                 res_valid,
	input  wire logic            res_stall,
	output rte_pkg::coord_t      res [3],
	output logic                 res_sat
);

	localparam logic signed [rte_pkg::PROD_W-1:0] RND_HALF = rte_pkg::PROD_W'(64'sd1 <<< 29);
	localparam logic signed [rte_pkg::ACC_W-1:0] CMAX = rte_pkg::ACC_W'(64'sd2147483647);
	localparam logic signed [rte_pkg::ACC_W-1:0] CMIN = -rte_pkg::ACC_W'(64'sd2147483648);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [rte_pkg::DIFF_W-1:0] d_s1 [3];
	logic signed [rte_pkg::PROD_W-1:0] prod_s2 [3][3];
	logic signed [rte_pkg::ACC_W-1:0]  acc_s3 [3];
	rte_pkg::coord_t res_s4 [3];
	logic sat_s4;

	rte_pkg::coef_t coef [3][3];
	logic signed [rte_pkg::ACC_W-1:0] sum [3];
	rte_pkg::coord_t clamp [3];
	logic [2:0] csat;

	assign en4  = !v_s4 || !res_stall;
	assign en3  = !v_s3 || en4;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;
	assign room = en1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++)
				coef[i][j] = xf.inverse ? xf.mat[j][i] : xf.mat[i][j];
		end
		for (int i = 0; i < 3; i++) begin
			sum[i] = xf.inverse ? '0 : rte_pkg::ACC_W'(xf.offset[i]);
			for (int j = 0; j < 3; j++)
				sum[i] = sum[i] + rte_pkg::ACC_W'((prod_s2[i][j] + RND_HALF) >>> 30);
		end
		for (int i = 0; i < 3; i++) begin
			csat[i] = 1'b1;
			if (acc_s3[i] > CMAX)
				clamp[i] = rte_pkg::COORD_W'(CMAX);
			else if (acc_s3[i] < CMIN)
				clamp[i] = rte_pkg::COORD_W'(CMIN);
			else begin
				clamp[i] = rte_pkg::COORD_W'(acc_s3[i]);
				csat[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= take;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int j = 0; j < 3; j++)
				d_s1[j] <= xf.inverse ? rte_pkg::DIFF_W'(pin[j]) - rte_pkg::DIFF_W'(xf.offset[j])
					: rte_pkg::DIFF_W'(pin[j]);
		end
		if (en2) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					prod_s2[i][j] <= rte_pkg::PROD_W'(coef[i][j]) * rte_pkg::PROD_W'(d_s1[j]);
		end
		if (en3) begin
			for (int i = 0; i < 3; i++)
				acc_s3[i] <= sum[i];
		end
		if (en4) begin
			for (int i = 0; i < 3; i++)
				res_s4[i] <= clamp[i];
			sat_s4 <= |csat;
		end
	end

	assign res_valid = v_s4;
	assign res       = res_s4;
	assign res_sat   = sat_s4;

	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && res_stall && v_s3) |=> (v_s3 && $stable(acc_s3[0])))
		else $error("stage 3 lost data under stall");
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && sat_s4) |-> (res_s4[0] == 32'sh7fffffff || res_s4[0] == 32'sh80000000 ||
			res_s4[1] == 32'sh7fffffff || res_s4[1] == 32'sh80000000 ||
			res_s4[2] == 32'sh7fffffff || res_s4[2] == 32'sh80000000))
		else $error("saturated flag without clamped coordinate");

endmodule
`default_nettype wire

// ----- hw/rtl/rigid_transform_3d_euler.sv -----
// A point accepted on the input passes stage registers s1 to s4 to out_*.
// Throughput: one point per cycle while out_stall is low and the matrix
// is ready, set by the four-stage point pipeline. After reset and after any
// angle write the matrix is rebuilt (per-angle CORDIC, multiplies, sum);
// in_stall is high meanwhile. Reset: identity angles, zero offset, forward.
`default_nettype none
module rigid_transform_3d_euler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [rte_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [rte_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic signed [31:0]          point_x,
	input  wire logic signed [31:0]          point_y,
	input  wire logic signed [31:0]          point_z,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [31:0]               out_x,
	output logic signed [31:0]               out_y,
	output logic signed [31:0]               out_z,
	output logic                             saturated
);

	// configuration registers
	rte_pkg::angle_t roll_q, pitch_q, yaw_q;
	rte_pkg::coord_t offset_q [3];
	logic inverse_q;
	logic angle_wr;

	rte_pkg::xform_t xf;
	rte_pkg::mat_t mat;
	logic mat_ready, room, take;
	rte_pkg::coord_t pin [3];
	rte_pkg::coord_t res [3];

	// only angle writes touch the matrix; offsets and the inverse flag feed
	// the datapath directly
	assign angle_wr = cfg_wr_en && (cfg_index == rte_pkg::REG_ROLL ||
		cfg_index == rte_pkg::REG_PITCH || cfg_index == rte_pkg::REG_YAW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q    <= '0;
			pitch_q   <= '0;
			yaw_q     <= '0;
			offset_q  <= '{default: '0};
			inverse_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rte_pkg::REG_ROLL:     roll_q      <= cfg_data[15:0];
				rte_pkg::REG_PITCH:    pitch_q     <= cfg_data[15:0];
				rte_pkg::REG_YAW:      yaw_q       <= cfg_data[15:0];
				rte_pkg::REG_OFFSET_X: offset_q[0] <= cfg_data;
				rte_pkg::REG_OFFSET_Y: offset_q[1] <= cfg_data;
				rte_pkg::REG_OFFSET_Z: offset_q[2] <= cfg_data;
				rte_pkg::REG_INVERSE:  inverse_q   <= cfg_data[0];
				default: ;  // unmapped index: write dropped
			endcase
		end
	end

	// matrix builder restarts on reset and on every angle write; it reads the
	// angle registers in the cycle after, once the write has landed
	rte_matrix u_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (angle_wr),
		.roll   (roll_q),
		.pitch  (pitch_q),
		.yaw    (yaw_q),
		.mat    (mat),
		.ready  (mat_ready)
	);

	assign xf.mat     = mat;
	assign xf.offset  = offset_q;
	assign xf.inverse = inverse_q;

	// a transaction enters when the matrix is valid and stage 1 has room
	assign in_stall = !(mat_ready && room);
	assign take     = in_valid && !in_stall;

	assign pin[0] = point_x;
	assign pin[1] = point_y;
	assign pin[2] = point_z;

	rte_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.xf        (xf),
		.take      (take),
		.room      (room),
		.pin       (pin),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.res       (res),
		.res_sat   (saturated)
	);

	assign out_x = res[0];
	assign out_y = res[1];
	assign out_z = res[2];

	a_no_take_unready: assert property (@(posedge clk) disable iff (!arst_n)
		!mat_ready |-> in_stall) else $error("transaction taken before matrix built");
	a_angle_wr_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		angle_wr |=> in_stall) else $error("input open right after angle write");

endmodule
`default_nettype wire

// ----- dv/rte_checker.sv -----
// Checker for the rigid transform block: watches the register port and both
// point channels, predicts each transformed point and compares it.
// Depends on rte_pkg for widths and register indexes.
`default_nettype none
module rte_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [rte_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [rte_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      in_valid,
	input  wire logic                      in_stall,
	input  wire logic signed [31:0]        point_x,
	input  wire logic signed [31:0]        point_y,
	input  wire logic signed [31:0]        point_z,
	input  wire logic                      out_valid,
	input  wire logic                      out_stall,
	input  wire logic signed [31:0]        out_x,
	input  wire logic signed [31:0]        out_y,
	input  wire logic signed [31:0]        out_z,
	input  wire logic                      saturated,
	output int                             fail_count,
	output int                             pending,
	output int                             checked,
	output int                             sat_seen
);

	typedef struct {
		logic signed [31:0] x, y, z;
		logic               sat;
	} point_res_t;

	localparam longint ATAN_Q31 [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81};

	rte_pkg::angle_t    roll, pitch, yaw;
	logic signed [31:0] ofs [3];
	logic               inv;
	point_res_t         expected_pts [$];

	function automatic longint q30_mul(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic void cordic_sincos(input rte_pkg::angle_t ang, output longint s,
			output longint c);
		longint z, x, y, nx;
		bit     flip;
		z = longint'(ang) * 65536;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > (64'sd1 <<< 30)) begin
			z = z - (64'sd1 <<< 31);
			flip = 1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z = z + (64'sd1 <<< 31);
			flip = 1;
		end
		for (int i = 0; i < rte_pkg::CORDIC_ITERS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - ATAN_Q31[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + ATAN_Q31[i];
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic point_res_t transform_point(logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		longint     sr, cr, sp, cp, sy, cy, acc;
		longint     m [3][3];
		longint     p [3];
		longint     r [3];
		point_res_t res;
		cordic_sincos(roll, sr, cr);
		cordic_sincos(pitch, sp, cp);
		cordic_sincos(yaw, sy, cy);
		m[0][0] = q30_mul(cy, cp);
		m[0][1] = q30_mul(q30_mul(cy, sp), sr) - q30_mul(sy, cr);
		m[0][2] = q30_mul(q30_mul(cy, sp), cr) + q30_mul(sy, sr);
		m[1][0] = q30_mul(sy, cp);
		m[1][1] = q30_mul(q30_mul(sy, sp), sr) + q30_mul(cy, cr);
		m[1][2] = q30_mul(q30_mul(sy, sp), cr) - q30_mul(cy, sr);
		m[2][0] = -sp;
		m[2][1] = q30_mul(cp, sr);
		m[2][2] = q30_mul(cp, cr);
		p[0] = px; p[1] = py; p[2] = pz;
		res.sat = 0;
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			if (inv) begin
				for (int j = 0; j < 3; j++)
					acc += q30_mul(m[j][i], p[j] - longint'(ofs[j]));
			end else begin
				for (int j = 0; j < 3; j++)
					acc += q30_mul(m[i][j], p[j]);
				acc += longint'(ofs[i]);
			end
			if (acc > 64'sd2147483647) begin
				acc = 64'sd2147483647;
				res.sat = 1;
			end else if (acc < -64'sd2147483648) begin
				acc = -64'sd2147483648;
				res.sat = 1;
			end
			r[i] = acc;
		end
		res.x = r[0][31:0];
		res.y = r[1][31:0];
		res.z = r[2][31:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		point_res_t want;
		if (!arst_n) begin
			roll = '0; pitch = '0; yaw = '0;
			ofs = '{default: '0};
			inv = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					rte_pkg::REG_ROLL:     roll   = cfg_data[15:0];
					rte_pkg::REG_PITCH:    pitch  = cfg_data[15:0];
					rte_pkg::REG_YAW:      yaw    = cfg_data[15:0];
					rte_pkg::REG_OFFSET_X: ofs[0] = cfg_data;
					rte_pkg::REG_OFFSET_Y: ofs[1] = cfg_data;
					rte_pkg::REG_OFFSET_Z: ofs[2] = cfg_data;
					rte_pkg::REG_INVERSE:  inv    = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_pts.size() == 0) begin
					$error("unexpected output transaction x=%0d y=%0d z=%0d", out_x, out_y, out_z);
					fail_count++;
				end else begin
					want = expected_pts.pop_front();
					checked++;
					if (saturated)
						sat_seen++;
					if (out_x !== want.x) begin
						$error("out_x expected %0d actual %0d", want.x, out_x);
						fail_count++;
					end
					if (out_y !== want.y) begin
						$error("out_y expected %0d actual %0d", want.y, out_y);
						fail_count++;
					end
					if (out_z !== want.z) begin
						$error("out_z expected %0d actual %0d", want.z, out_z);
						fail_count++;
					end
					if (saturated !== want.sat) begin
						$error("saturated expected %0d actual %0d", want.sat, saturated);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_pts.push_back(transform_point(point_x, point_y, point_z));
			pending = expected_pts.size();
		end
	end

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Top of the rigid transform testbench: clock, reset, register writes,
// point stimulus, output back-pressure and the final verdict.
// Depends on rte_pkg, rigid_transform_3d_euler and rte_checker.
`default_nettype none
module tb_top;

	// index with no register behind it
	localparam logic [rte_pkg::IDX_W-1:0] REG_NONE = 3'd7;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [rte_pkg::IDX_W-1:0]  cfg_index;
	logic [rte_pkg::CFG_W-1:0]  cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [31:0]         point_x, point_y, point_z;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [31:0]         out_x, out_y, out_z;
	logic                       saturated;
	int                         fail_count, pending, checked, sat_seen;

	// idling switch for both sides; long_hold asks the receiver for a long stall
	bit gaps_on;
	bit long_hold;
	int sent;

	rigid_transform_3d_euler u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .saturated(saturated)
	);

	rte_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .saturated(saturated),
		.fail_count(fail_count), .pending(pending), .checked(checked),
		.sat_seen(sat_seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Hard limit: far above the slowest legal run (matrix rebuilds, stalls, gaps).
	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: random stall bursts, plus one long hold-off on request so the
	// pipeline fills and pushes back on the input side.
	initial begin
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1;
				repeat (200) @(posedge clk);
				out_stall <= 0;
				long_hold = 0;
			end else if (gaps_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	// One register write per edge; caller lowers the enable afterwards.
	task automatic write_reg(input logic [rte_pkg::IDX_W-1:0] idx,
			input logic [rte_pkg::CFG_W-1:0] val);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Offer one point and hold it until the block takes it. Values seen right
	// after the edge are the pre-edge ones, so the test below is the handshake.
	task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		point_x  <= x;
		point_y  <= y;
		point_z  <= z;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Drain: everything in flight has come out, plus pipeline depth to spare.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_angle_word();
		case ($urandom_range(0, 5))
			0: return {16'($urandom_range(0, 65535)), 16'h8000};  // minus pi, junk above
			1: return 32'h0000_7fff;
			2: return 32'h0000_4000;                              // exactly a quarter turn
			3: return 32'hffff_c000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_offset();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h0020_0000))) - 32'h0010_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(0, 1))
			return $urandom;
		return 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
	endfunction

	task automatic random_config();
		write_reg(rte_pkg::REG_ROLL, rand_angle_word());
		write_reg(rte_pkg::REG_PITCH, rand_angle_word());
		write_reg(rte_pkg::REG_YAW, rand_angle_word());
		write_reg(rte_pkg::REG_OFFSET_X, rand_offset());
		write_reg(rte_pkg::REG_OFFSET_Y, rand_offset());
		write_reg(rte_pkg::REG_OFFSET_Z, rand_offset());
		write_reg(rte_pkg::REG_INVERSE, $urandom);
		cfg_wr_en <= 0;
	endtask

	initial begin
		cfg_wr_en = 0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 0;
		point_x   = '0;
		point_y   = '0;
		point_z   = '0;
		gaps_on   = 1;
		long_hold = 0;
		sent      = 0;
		arst_n    = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// Directed, reset settings: identity rotation, so extremes pass through.
		send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0);
		send_point(32'sh8000_0000, 32'sh7fff_ffff, -32'sh1);
		send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh7fff_ffff);
		drain();

		// Roll at minus pi folds to zero with a sign flip; pitch exactly at a quarter turn;
		// yaw at its top; X and Y offsets at the rails so the forward sum clamps.
		write_reg(rte_pkg::REG_ROLL, 32'h1234_8000);
		write_reg(rte_pkg::REG_PITCH, 32'h0000_4000);
		write_reg(rte_pkg::REG_YAW, 32'h0000_7fff);
		write_reg(rte_pkg::REG_OFFSET_X, 32'h7fff_ffff);
		write_reg(rte_pkg::REG_OFFSET_Y, 32'h8000_0000);
		write_reg(rte_pkg::REG_OFFSET_Z, 32'h0003_0000);
		write_reg(REG_NONE, 32'hffff_ffff);
		cfg_wr_en <= 0;
		send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
		send_point(32'sh0, 32'sh0, 32'sh0);
		drain();

		// Inverse: p - t spans 33 bits at the extremes.
		write_reg(rte_pkg::REG_INVERSE, 32'hffff_fffe);      // bit 0 clear, junk above
		write_reg(rte_pkg::REG_INVERSE, 32'h0000_0001);
		write_reg(rte_pkg::REG_PITCH, 32'hffff_c000);
		write_reg(rte_pkg::REG_OFFSET_X, 32'h8000_0000);
		cfg_wr_en <= 0;
		send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
		send_point(32'sh0, 32'sh0, 32'sh0);
		send_point(32'sh0005_8000, -32'sh0002_4000, 32'sh0000_0001);
		drain();

		// Random phases, fresh settings each; the fifth gets the long hold-off.
		for (int ph = 0; ph < 9; ph++) begin
			random_config();
			if (ph == 8)
				gaps_on = 0;
			for (int n = 0; n < 66; n++) begin
				if (ph == 4 && n == 5)
					long_hold = 1;
				send_point(rand_coord(), rand_coord(), rand_coord());
			end
			drain();
		end

		$display("Covered %0d points (%0d checked, %0d clamped) over directed and random settings,",
			sent, checked, sat_seen);
		$display("forward and inverse, with folded angles, rail offsets and back-pressure.");
		if (fail_count == 0 && pending == 0 && checked == sent)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/rte_pkg.sv
hw/rtl/rte_matrix.sv
hw/rtl/rte_pipe.sv
hw/rtl/rigid_transform_3d_euler.sv
dv/rte_checker.sv
dv/tb_top.sv
